// ===== rtl/core/kq_pkg.sv =====
// Shared types, constants and the nonlinear function for the KeeLoq core.
package kq_pkg;

  localparam int unsigned BLOCK_W      = 32;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned KIDX_W       = 6;
  localparam int unsigned ROUNDS_DEF   = 528;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_ADDR_W   = 4;

  localparam logic [31:0] NLF_TABLE    = 32'h3A5C742E;

  // register index, taken from paddr bit 3 (8-byte register spacing)
  localparam logic REG_CIPHER_KEY = 1'b0;

  // operation codes carried in tuser
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_XFER = 3'b100
  } kq_state_t;

  typedef struct packed {
    logic load;   // take the input block
    logic shift;  // one round
    logic dec;    // shift toward bit 31 (decrypt) instead of toward bit 0
  } kq_cell_ctrl_t;

  function automatic logic nlf(input logic a, input logic b, input logic c,
                               input logic d, input logic e);
    logic [4:0] sel;
    sel = {a, b, c, d, e};
    return NLF_TABLE[sel];
  endfunction

endpackage

// ===== rtl/core/keeloq_block_cipher.sv =====
// KeeLoq block cipher top level: 32 bit cells, feedback, key register, control.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: block_in[31:0]; tuser: command
//  out_    | out | out_tvalid/tready  | tdata: block_out[31:0]
//  cfg_    | in  | APB, pready high   | addr 0: cipher_key[63:0]
//
// One round per clock in the cell chain: an item passes through load, ROUND_COUNT
// rounds and the transfer to the output register.
// The next item is accepted once the previous result sits in the output
// register, even while out_tready is low; a stalled output holds the chain.
// rst_n is synchronous; it clears control state and the key, not the data cells.
module keeloq_block_cipher
  import kq_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = ROUNDS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BLOCK_W-1:0]    in_tdata,   // [31:0] block_in
  input  logic                  in_tuser,   // [0] command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BLOCK_W-1:0]    out_tdata,  // [31:0] block_out
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned CNT_W = $clog2(ROUND_COUNT + 1);
  localparam logic [KIDX_W-1:0] KEY_DEC_START = KIDX_W'((ROUND_COUNT - 1) % KEY_W);

  kq_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [KIDX_W-1:0]   kidx_r, kidx_nxt;
  logic                dec_r, dec_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BLOCK_W-1:0]  out_data_r, out_data_nxt;

  logic [KEY_W-1:0]    key;
  logic [BLOCK_W-1:0]  blk;
  logic                fb;
  kq_cell_ctrl_t       cell_ctrl;
  logic                in_fire;
  logic                slot_free;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_tready;

  assign cell_ctrl.load  = in_fire;
  assign cell_ctrl.shift = (state_r == ST_RUN);
  assign cell_ctrl.dec   = dec_r;

  kq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .key     (key)
  );

  kq_feedback u_fb (
    .blk     (blk),
    .dec     (dec_r),
    .key_bit (key[kidx_r]),
    .fb      (fb)
  );

  // encrypt: bit i takes bit i+1, fb enters at 31; decrypt: bit i takes i-1, fb at 0
  for (genvar i = 0; i < BLOCK_W; i++) begin : g_cell
    logic upper;
    logic lower;
    if (i == BLOCK_W - 1) begin : g_top
      assign upper = fb;
    end else begin : g_mid_u
      assign upper = blk[i+1];
    end
    if (i == 0) begin : g_bot
      assign lower = fb;
    end else begin : g_mid_l
      assign lower = blk[i-1];
    end
    kq_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .load_bit   (in_tdata[i]),
      .from_upper (upper),
      .from_lower (lower),
      .bit_q      (blk[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kidx_nxt      = kidx_r;
    dec_nxt       = dec_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RUN;
          cnt_nxt   = CNT_W'(ROUND_COUNT);
          dec_nxt   = (in_tuser == CMD_DECRYPT);
          kidx_nxt  = (in_tuser == CMD_DECRYPT) ? KEY_DEC_START : '0;
        end
      end
      ST_RUN: begin
        cnt_nxt  = cnt_r - CNT_W'(1);
        kidx_nxt = dec_r ? (kidx_r - KIDX_W'(1)) : (kidx_r + KIDX_W'(1));
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_XFER;
        end
      end
      ST_XFER: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = blk;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      kidx_r      <= '0;
      dec_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      kidx_r      <= kidx_nxt;
      dec_r       <= dec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_RUN) && (cnt_r == CNT_W'(ROUND_COUNT)))
    else $error("accepted block did not start the round sequence");

  a_run_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r != '0) && !in_tready)
    else $error("round counter empty or input open during rounds");

  a_xfer_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_XFER) && slot_free |=> out_tvalid && (state_r == ST_IDLE))
    else $error("finished block not moved to the output register");

endmodule

// ===== rtl/core/kq_cell.sv =====
// One bit of the NLFSR data register: loads, or takes a neighbor's bit.
module kq_cell
  import kq_pkg::*;
(
  input  logic          clk,
  input  kq_cell_ctrl_t ctrl,
  input  logic          load_bit,
  input  logic          from_upper,
  input  logic          from_lower,
  output logic          bit_q
);

  logic bit_r;
  logic bit_nxt;

  always_comb begin
    bit_nxt = bit_r;
    if (ctrl.load) begin
      bit_nxt = load_bit;
    end else if (ctrl.shift) begin
      bit_nxt = ctrl.dec ? from_lower : from_upper;
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
  end

  assign bit_q = bit_r;

endmodule

// ===== rtl/core/kq_feedback.sv =====
// Round feedback bit: NLF taps, linear taps and the key bit.
module kq_feedback
  import kq_pkg::*;
(
  input  logic [BLOCK_W-1:0] blk,
  input  logic               dec,
  input  logic               key_bit,
  output logic               fb
);

  logic nl_enc;
  logic nl_dec;

  assign nl_enc = nlf(blk[31], blk[26], blk[20], blk[9], blk[1]);
  assign nl_dec = nlf(blk[30], blk[25], blk[19], blk[8], blk[0]);

  assign fb = dec ? (nl_dec ^ blk[31] ^ blk[15] ^ key_bit)
                  : (nl_enc ^ blk[16] ^ blk[0] ^ key_bit);

endmodule

// ===== rtl/core/kq_cfg_regs.sv =====
// APB-style register port holding the 64-bit cipher key.
module kq_cfg_regs
  import kq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [KEY_W-1:0]      key
);

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;
  logic             hit;

  // low address bits are ignored; bit 3 selects the register
  assign hit    = (paddr[3] == REG_CIPHER_KEY);
  assign pready = 1'b1;

  always_comb begin
    key_nxt = key_r;
    if (psel && penable && pwrite && hit) begin
      key_nxt = pwdata[KEY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  assign prdata = hit ? key_r : '0;
  assign key    = key_r;

endmodule
